>>> hw/rtl/servo_pwm_command_mapper_macros.svh
// Assertion macros for the servo pulse mapper
`ifndef SERVO_PWM_COMMAND_MAPPER_MACROS_SVH
`define SERVO_PWM_COMMAND_MAPPER_MACROS_SVH

// check a condition at every clock edge out of reset
`define SPCM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// check a delayed consequence of the antecedent
`define SPCM_ASSERT_AFTER2(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/spcm_pkg.sv
package spcm_pkg;

  localparam int CHANNELS       = 12;
  localparam int CH_W           = 4;
  localparam int PULSE_W        = 12;
  localparam int CMD_W          = 16;
  localparam int COUNT_W        = 4;
  localparam int PADDR_W        = 5;
  localparam int PDATA_W        = 32;

  localparam logic [PULSE_W-1:0] CAL_LOW_LIMIT  = 12'd800;
  localparam logic [PULSE_W-1:0] CAL_HIGH_LIMIT = 12'd2200;
  localparam logic [PULSE_W-1:0] DEFAULT_MIN    = 12'd1000;
  localparam logic [PULSE_W-1:0] DEFAULT_CENTER = 12'd1500;
  localparam logic [PULSE_W-1:0] DEFAULT_MAX    = 12'd2000;

  localparam logic signed [CMD_W-1:0] Q_ONE     = 16'sd16384;
  localparam logic signed [CMD_W-1:0] Q_NEG_ONE = -16'sd16384;
  localparam int Q_SHIFT = 14;
  localparam int ACC_W   = 30;
  localparam logic signed [ACC_W-1:0] Q_HALF = 30'sd8192;

  typedef enum logic [2:0] {
    REG_PULSE_MINIMUM     = 3'd0,
    REG_PULSE_CENTER      = 3'd1,
    REG_PULSE_MAXIMUM     = 3'd2,
    REG_REVERSE_CHANNELS  = 3'd3,
    REG_FAILSAFE_PULSE    = 3'd4,
    REG_RESERVED_CHANNELS = 3'd5,
    REG_CHANNELS_IN_USE   = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    SRC_MAPPED   = 2'd0,
    SRC_FAILSAFE = 2'd1,
    SRC_DISABLED = 2'd2
  } source_t;

  typedef struct packed {
    logic [PULSE_W-1:0]  pulse_minimum;
    logic [PULSE_W-1:0]  pulse_center;
    logic [PULSE_W-1:0]  pulse_maximum;
    logic [CHANNELS-1:0] reverse_channels;
    logic [PULSE_W-1:0]  failsafe_pulse;
    logic [CHANNELS-1:0] reserved_channels;
    logic [COUNT_W-1:0]  channels_in_use;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]         channel_index;
    logic signed [CMD_W-1:0] command_value;
    logic                    sample_valid;
    logic                    value_finite;
    logic                    route_assigned;
  } item_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_width;
    logic               output_enabled;
    source_t            drive_source;
  } result_t;

endpackage

>>> hw/rtl/spcm_regs.sv
module spcm_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spcm_pkg::PADDR_W-1:0]  paddr,
  input  logic [spcm_pkg::PDATA_W-1:0]  pwdata,
  output logic [spcm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output spcm_pkg::cfg_t                cfg
);
  import spcm_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_minimum     <= DEFAULT_MIN;
      cfg.pulse_center      <= DEFAULT_CENTER;
      cfg.pulse_maximum     <= DEFAULT_MAX;
      cfg.reverse_channels  <= '0;
      cfg.failsafe_pulse    <= '0;
      cfg.reserved_channels <= '0;
      cfg.channels_in_use   <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PULSE_MINIMUM:     cfg.pulse_minimum     <= pwdata[PULSE_W-1:0];
        REG_PULSE_CENTER:      cfg.pulse_center      <= pwdata[PULSE_W-1:0];
        REG_PULSE_MAXIMUM:     cfg.pulse_maximum     <= pwdata[PULSE_W-1:0];
        REG_REVERSE_CHANNELS:  cfg.reverse_channels  <= pwdata[CHANNELS-1:0];
        REG_FAILSAFE_PULSE:    cfg.failsafe_pulse    <= pwdata[PULSE_W-1:0];
        REG_RESERVED_CHANNELS: cfg.reserved_channels <= pwdata[CHANNELS-1:0];
        REG_CHANNELS_IN_USE:   cfg.channels_in_use   <= pwdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_PULSE_MINIMUM:     prdata[PULSE_W-1:0]  = cfg.pulse_minimum;
      REG_PULSE_CENTER:      prdata[PULSE_W-1:0]  = cfg.pulse_center;
      REG_PULSE_MAXIMUM:     prdata[PULSE_W-1:0]  = cfg.pulse_maximum;
      REG_REVERSE_CHANNELS:  prdata[CHANNELS-1:0] = cfg.reverse_channels;
      REG_FAILSAFE_PULSE:    prdata[PULSE_W-1:0]  = cfg.failsafe_pulse;
      REG_RESERVED_CHANNELS: prdata[CHANNELS-1:0] = cfg.reserved_channels;
      REG_CHANNELS_IN_USE:   prdata[COUNT_W-1:0]  = cfg.channels_in_use;
      default:               prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/spcm_map.sv
module spcm_map (
  input  spcm_pkg::cfg_t    cfg,
  input  spcm_pkg::item_t   item,
  output spcm_pkg::result_t res
);
  import spcm_pkg::*;

  logic                    cal_ok;
  logic [PULSE_W-1:0]      lo;
  logic [PULSE_W-1:0]      mid;
  logic [PULSE_W-1:0]      hi;
  logic [PULSE_W-1:0]      fs;
  logic [COUNT_W-1:0]      count;
  logic                    in_range;
  logic                    reserved;
  logic                    rev;
  logic signed [CMD_W-1:0] v_clamp;
  logic signed [CMD_W-1:0] v;
  logic signed [PULSE_W:0] span;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic [PULSE_W-1:0]      mapped;

  assign cal_ok = !(cfg.pulse_minimum < CAL_LOW_LIMIT || cfg.pulse_maximum > CAL_HIGH_LIMIT ||
                    cfg.pulse_minimum >= cfg.pulse_center ||
                    cfg.pulse_center >= cfg.pulse_maximum);
  assign lo  = cal_ok ? cfg.pulse_minimum : DEFAULT_MIN;
  assign mid = cal_ok ? cfg.pulse_center  : DEFAULT_CENTER;
  assign hi  = cal_ok ? cfg.pulse_maximum : DEFAULT_MAX;

  always_comb begin
    priority if (cfg.failsafe_pulse == '0) fs = '0;
    else if (cfg.failsafe_pulse < lo)      fs = lo;
    else if (cfg.failsafe_pulse > hi)      fs = hi;
    else                                   fs = cfg.failsafe_pulse;
  end

  assign count    = (cfg.channels_in_use > COUNT_W'(CHANNELS)) ? COUNT_W'(CHANNELS)
                                                               : cfg.channels_in_use;
  assign in_range = item.channel_index < count;
  assign reserved = in_range && cfg.reserved_channels[item.channel_index];
  assign rev      = in_range && cfg.reverse_channels[item.channel_index];

  always_comb begin
    priority if (item.command_value < Q_NEG_ONE) v_clamp = Q_NEG_ONE;
    else if (item.command_value > Q_ONE)          v_clamp = Q_ONE;
    else                                          v_clamp = item.command_value;
  end

  assign v    = rev ? -v_clamp : v_clamp;
  assign span = (v < 0) ? $signed({1'b0, mid - lo}) : $signed({1'b0, hi - mid});
  assign prod = ACC_W'(v) * ACC_W'(span);
  assign acc  = $signed(ACC_W'({mid, {Q_SHIFT{1'b0}}})) + prod + Q_HALF;
  assign mapped = acc[Q_SHIFT +: PULSE_W];

  always_comb begin
    res.pulse_width    = '0;
    res.output_enabled = 1'b0;
    res.drive_source   = SRC_DISABLED;
    if (in_range && !reserved && item.route_assigned) begin
      priority if (item.sample_valid && item.value_finite) begin
        res.pulse_width    = mapped;
        res.output_enabled = 1'b1;
        res.drive_source   = SRC_MAPPED;
      end else if (fs != '0) begin
        res.pulse_width    = fs;
        res.output_enabled = 1'b1;
        res.drive_source   = SRC_FAILSAFE;
      end else begin
        res.drive_source   = SRC_DISABLED;
      end
    end
  end

endmodule

>>> hw/rtl/servo_pwm_command_mapper.sv
// Flow: a request taken at a clock edge is captured in the input register, and its result
// is then captured in the result register, with strobe high for one cycle.
// Throughput: one request per cycle; the input register and the result register
// form a two-stage pipeline around one 16x13 multiply.
// Reset: rst clears the pipeline and restores the calibration registers to their
// defaults; busy is high only while rst is high.
`include "servo_pwm_command_mapper_macros.svh"

module servo_pwm_command_mapper (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [spcm_pkg::PADDR_W-1:0]       paddr,
  input  logic [spcm_pkg::PDATA_W-1:0]       pwdata,
  output logic [spcm_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready,
  input  logic                               start,
  output logic                               busy,
  input  logic [spcm_pkg::CH_W-1:0]          channel_index,
  input  logic signed [spcm_pkg::CMD_W-1:0]  command_value,
  input  logic                               sample_valid,
  input  logic                               value_finite,
  input  logic                               route_assigned,
  output logic                               strobe,
  output logic [spcm_pkg::CH_W-1:0]          out_channel,
  output logic [spcm_pkg::PULSE_W-1:0]       pulse_width,
  output logic                               output_enabled,
  output logic [1:0]                         drive_source
);
  import spcm_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  result_t res_next;
  logic    accepted;

  assign busy     = rst;
  assign accepted = start && !busy;

  spcm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spcm_map u_map (
    .cfg  (cfg),
    .item (item),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      item_valid <= accepted;
      strobe     <= item_valid;
    end
    if (accepted) begin
      item.channel_index  <= channel_index;
      item.command_value  <= command_value;
      item.sample_valid   <= sample_valid;
      item.value_finite   <= value_finite;
      item.route_assigned <= route_assigned;
    end
    if (item_valid) begin
      out_channel    <= item.channel_index;
      pulse_width    <= res_next.pulse_width;
      output_enabled <= res_next.output_enabled;
      drive_source   <= res_next.drive_source;
    end
  end

  `SPCM_ASSERT_AFTER2(a_strobe_follows, accepted, strobe, "request produced no result")
  `SPCM_ASSERT_AFTER2(a_no_spurious, !accepted, !strobe, "result without a request")
  `SPCM_ASSERT_AFTER2(a_channel_kept, accepted, out_channel == $past(channel_index, 2),
    "result channel does not match request")
  `SPCM_ASSERT_ALWAYS(a_enable_source,
    !strobe || (output_enabled == (drive_source != SRC_DISABLED)),
    "enable flag disagrees with drive source")
  `SPCM_ASSERT_ALWAYS(a_disabled_zero,
    !strobe || output_enabled || (pulse_width == '0),
    "disabled output carries a pulse")

endmodule
